>>> hdl/irkar_pkg.sv
// Shared types and constants for the key auto-repeat unit.
package irkar_pkg;

  localparam int CODE_BITS_DEF = 32;
  localparam int KEY_CODE_W    = 32;
  localparam int TICK_W        = 16;
  localparam int LEN_W         = 4;
  localparam int CFG_ADDR_W    = 2;
  localparam int IN_TDATA_W    = 40;

  localparam logic [TICK_W-1:0]     FIRST_DELAY_RST  = 16'd500;
  localparam logic [TICK_W-1:0]     REPEAT_DELAY_RST = 16'd100;
  localparam logic [TICK_W-1:0]     MAX_REPEATS_RST  = 16'd500;
  localparam logic [KEY_CODE_W-1:0] REMOVE_WORD      = 32'h00FF_FFFF;
  localparam logic [LEN_W-1:0]      LEN_LONG         = 4'd8;
  localparam logic [LEN_W-1:0]      LEN_SHORT        = 4'd6;
  localparam logic [KEY_CODE_W-1:0] SHORT_MIN_WORD   = 32'd2;

  typedef enum logic [1:0] {
    REQ_REPORT = 2'd0,
    REQ_TICK   = 2'd1,
    REQ_ERROR  = 2'd2,
    REQ_UNUSED = 2'd3
  } req_type_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_FIRST_DELAY  = 2'd0,
    CFG_REPEAT_DELAY = 2'd1,
    CFG_MAX_REPEATS  = 2'd2,
    CFG_NONE         = 2'd3
  } cfg_addr_t;

  typedef struct packed {
    logic [TICK_W-1:0] first_delay;
    logic [TICK_W-1:0] repeat_delay;
    logic [TICK_W-1:0] max_repeats;
  } cfg_t;

  typedef struct packed {
    req_type_t             req_type;
    logic [LEN_W-1:0]      report_length;
    logic [KEY_CODE_W-1:0] report_word;
  } item_t;

  typedef struct packed {
    logic                  valid;
    logic [KEY_CODE_W-1:0] key_code;
    logic                  is_repeat;
    logic                  device_removed;
  } result_t;

endpackage

>>> hdl/ir_key_auto_repeat_unit.sv
// Top level of the key auto-repeat unit: configuration, handshake and result register.
//
// Usage: the input stream carries one request per item. in_tuser holds the
// request kind (receiver report, millisecond tick, device error); in_tdata
// holds the report length and the first report word. A press delivers its
// code, ticks count down the first and then the repeat delay, and each
// expiry delivers the held code again. A device error, the removal word or
// reaching the repeat limit delivers one removal item and halts the unit.
// Each input item yields zero or one output item on out_tdata/out_tuser.
// out_tvalid rises in the cycle after acceptance. Throughput: one item per
// cycle, sustained; the single result register limits it only while the
// receiver stalls.
// Reset: synchronous, active low; delays return to 500 and 100 ticks, the
// repeat limit to 500, all key state clears and the halt lifts.
// Stall: while out_tready is low and a result is held, in_tready drops; it
// rises again in the cycle the held result is taken.
// Configuration: write cfg_* only while no item is in flight.
module ir_key_auto_repeat_unit import irkar_pkg::*; #(
  parameter int CODE_BITS = CODE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,   // report_length[3:0], report_word[35:4], zero pad
  input  logic [1:0]            in_tuser,   // req_type[1:0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [KEY_CODE_W-1:0] out_tdata,  // key_code[31:0]
  output logic [1:0]            out_tuser,  // is_repeat[0], device_removed[1]
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [TICK_W-1:0]     cfg_wdata
);

  cfg_t    cfg_r, cfg_nxt;
  item_t   item;
  result_t res;
  logic    fire;

  logic                  out_valid_r, out_valid_nxt;
  logic [KEY_CODE_W-1:0] out_code_r, out_code_nxt;
  logic [1:0]            out_user_r, out_user_nxt;

  assign in_tready = !out_valid_r || out_tready;
  assign fire      = in_tvalid && in_tready;

  assign item.req_type      = req_type_t'(in_tuser);
  assign item.report_length = in_tdata[LEN_W-1:0];
  assign item.report_word   = in_tdata[LEN_W+KEY_CODE_W-1:LEN_W];

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_addr_t'(cfg_addr))
        CFG_FIRST_DELAY:  cfg_nxt.first_delay  = cfg_wdata;
        CFG_REPEAT_DELAY: cfg_nxt.repeat_delay = cfg_wdata;
        CFG_MAX_REPEATS:  cfg_nxt.max_repeats  = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  irkar_core #(
    .CODE_BITS(CODE_BITS)
  ) u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .fire (fire),
    .item (item),
    .cfg  (cfg_r),
    .res  (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_code_nxt  = out_code_r;
    out_user_nxt  = out_user_r;
    if (fire) begin
      out_valid_nxt = res.valid;
      out_code_nxt  = res.key_code;
      out_user_nxt  = {res.device_removed, res.is_repeat};
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first_delay  <= FIRST_DELAY_RST;
      cfg_r.repeat_delay <= REPEAT_DELAY_RST;
      cfg_r.max_repeats  <= MAX_REPEATS_RST;
      out_valid_r        <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_code_r <= out_code_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_code_r;
  assign out_tuser  = out_user_r;

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !fire)
    else $error("item accepted over a stalled result");

  a_removal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_user_r[1]) |-> (out_code_r == '0 && !out_user_r[0]))
    else $error("removal item carries a code");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res.valid) |=> out_valid_r)
    else $error("result lost");

endmodule

>>> hdl/irkar_core.sv
// Press, release, countdown and removal state of the key auto-repeat unit.
module irkar_core import irkar_pkg::*; #(
  parameter int CODE_BITS = CODE_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    fire,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res
);

  logic                  key_held_r, key_held_nxt;
  logic                  halted_r, halted_nxt;
  logic [TICK_W-1:0]     delay_left_r, delay_left_nxt;
  logic [TICK_W-1:0]     repeats_done_r, repeats_done_nxt;
  logic [CODE_BITS-1:0]  held_code_r, held_code_nxt;
  logic [CODE_BITS-1:0]  last_r, last_nxt;

  logic                  press;
  logic [TICK_W-1:0]     count_inc;
  logic [CODE_BITS-1:0]  word_code;
  logic [CODE_BITS-1:0]  deliver_code;
  logic                  do_deliver;
  logic                  do_remove;

  assign press = ((item.report_length == LEN_LONG) && (item.report_word != '0)) ||
                 ((item.report_length == LEN_SHORT) && (item.report_word > SHORT_MIN_WORD));
  assign count_inc = repeats_done_r + TICK_W'(1);
  assign word_code = item.report_word[CODE_BITS-1:0];

  always_comb begin
    key_held_nxt     = key_held_r;
    halted_nxt       = halted_r;
    delay_left_nxt   = delay_left_r;
    repeats_done_nxt = repeats_done_r;
    held_code_nxt    = held_code_r;
    last_nxt         = last_r;
    deliver_code     = held_code_r;
    do_deliver       = 1'b0;
    do_remove        = 1'b0;
    if (fire && !halted_r) begin
      case (item.req_type)
        REQ_ERROR: begin
          do_remove = 1'b1;
        end
        REQ_REPORT: begin
          if (!press) begin
            key_held_nxt = 1'b0;
            last_nxt     = '0;
          end else if (item.report_word == REMOVE_WORD) begin
            do_remove = 1'b1;
          end else begin
            key_held_nxt     = 1'b1;
            repeats_done_nxt = '0;
            delay_left_nxt   = cfg.first_delay;
            held_code_nxt    = word_code;
            deliver_code     = word_code;
            do_deliver       = 1'b1;
          end
        end
        REQ_TICK: begin
          if (key_held_r) begin
            if (delay_left_r > TICK_W'(1)) begin
              delay_left_nxt = delay_left_r - TICK_W'(1);
            end else begin
              repeats_done_nxt = count_inc;
              if (count_inc >= cfg.max_repeats) begin
                do_remove = 1'b1;
              end else begin
                delay_left_nxt = cfg.repeat_delay;
                do_deliver     = 1'b1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
    if (do_remove) begin
      halted_nxt   = 1'b1;
      key_held_nxt = 1'b0;
    end
    if (do_deliver && (deliver_code != last_r)) begin
      last_nxt = deliver_code;
    end

    res.valid          = do_deliver || do_remove;
    res.device_removed = do_remove;
    res.is_repeat      = do_deliver && (deliver_code == last_r);
    res.key_code       = do_deliver ? KEY_CODE_W'(deliver_code) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_held_r     <= 1'b0;
      halted_r       <= 1'b0;
      delay_left_r   <= '0;
      repeats_done_r <= '0;
      held_code_r    <= '0;
      last_r         <= '0;
    end else begin
      key_held_r     <= key_held_nxt;
      halted_r       <= halted_nxt;
      delay_left_r   <= delay_left_nxt;
      repeats_done_r <= repeats_done_nxt;
      held_code_r    <= held_code_nxt;
      last_r         <= last_nxt;
    end
  end

  a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r)
    else $error("halt state left without reset");

  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |-> !res.valid)
    else $error("result produced while halted");

  a_removal_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && res.device_removed) |=> (halted_r && !key_held_r))
    else $error("removal did not halt the unit");

  a_held_not_halted: assert property (@(posedge clk) disable iff (!rst_n)
    key_held_r |-> !halted_r)
    else $error("key held while halted");

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the key auto-repeat unit: stream stimulus, predictor and checker.
`timescale 1ns / 100ps

module testbench;
  import irkar_pkg::*;

  localparam logic [KEY_CODE_W-1:0] CODE_MASK =
    {KEY_CODE_W{1'b1}} >> (KEY_CODE_W - CODE_BITS_DEF);

  typedef struct packed {
    logic [KEY_CODE_W-1:0] key_code;
    logic                  is_repeat;
    logic                  device_removed;
  } key_event_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [1:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [KEY_CODE_W-1:0] out_tdata;
  logic [1:0]            out_tuser;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = CFG_NONE;
  logic [TICK_W-1:0]     cfg_wdata = '0;

  ir_key_auto_repeat_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state and register copy
  cfg_t                  dev_cfg = '{FIRST_DELAY_RST, REPEAT_DELAY_RST, MAX_REPEATS_RST};
  bit                    held = 1'b0;
  logic [TICK_W-1:0]     delay_left = '0;
  logic [TICK_W-1:0]     repeats_done = '0;
  logic [KEY_CODE_W-1:0] held_code = '0;
  logic [KEY_CODE_W-1:0] last_sent = '0;
  bit                    halted = 1'b0;

  item_t      request_queue[$];
  key_event_t key_events_due[$];
  item_t      next_req;
  key_event_t want;
  int         mismatches;
  int         idle_in_pct;
  int         stall_pct;
  int         ticks_since_press;
  logic [KEY_CODE_W-1:0] last_code = 32'h0000_0041;

  function automatic bit is_press(logic [LEN_W-1:0] len, logic [KEY_CODE_W-1:0] word);
    return (len == LEN_LONG && word != 0) || (len == LEN_SHORT && word > SHORT_MIN_WORD);
  endfunction

  function automatic item_t make_req(req_type_t kind, logic [LEN_W-1:0] len,
                                     logic [KEY_CODE_W-1:0] word);
    item_t it;
    it.req_type      = kind;
    it.report_length = len;
    it.report_word   = word;
    return it;
  endfunction

  task automatic declare_removal();
    halted = 1'b1;
    held   = 1'b0;
    key_events_due.push_back('{'0, 1'b0, 1'b1});
  endtask

  task automatic deliver_code(logic [KEY_CODE_W-1:0] code);
    logic rep;
    rep = (code == last_sent);
    if (!rep)
      last_sent = code;
    key_events_due.push_back('{code & CODE_MASK, rep, 1'b0});
  endtask

  task automatic step_autorepeat(item_t it);
    if (!halted) begin
      case (it.req_type)
        REQ_ERROR: declare_removal();
        REQ_REPORT: begin
          if (!is_press(it.report_length, it.report_word)) begin
            held      = 1'b0;
            last_sent = '0;
          end else if (it.report_word == REMOVE_WORD) begin
            declare_removal();
          end else begin
            held         = 1'b1;
            repeats_done = '0;
            delay_left   = dev_cfg.first_delay;
            held_code    = it.report_word & CODE_MASK;
            deliver_code(held_code);
          end
        end
        REQ_TICK: begin
          if (held) begin
            if (delay_left > 1) begin
              delay_left = delay_left - 1'b1;
            end else begin
              repeats_done = repeats_done + 1'b1;
              if (repeats_done >= dev_cfg.max_repeats) begin
                declare_removal();
              end else begin
                delay_left = dev_cfg.repeat_delay;
                deliver_code(held_code);
              end
            end
          end
        end
        default: ;
      endcase
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        step_autorepeat(make_req(req_type_t'(in_tuser), in_tdata[3:0], in_tdata[35:4]));
      if (!in_tvalid || in_tready) begin
        if (request_queue.size() != 0 && $urandom_range(0, 99) >= idle_in_pct) begin
          next_req = request_queue.pop_front();
          in_tdata  <= {{(IN_TDATA_W - 36){1'b0}}, next_req.report_word,
                        next_req.report_length};
          in_tuser  <= next_req.req_type;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (key_events_due.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual code %h flags %b",
                   $time, out_tdata, out_tuser);
          mismatches++;
        end else begin
          want = key_events_due.pop_front();
          if (out_tdata !== want.key_code) begin
            $display("%0t: key_code expected %h actual %h", $time, want.key_code, out_tdata);
            mismatches++;
          end
          if (out_tuser[0] !== want.is_repeat) begin
            $display("%0t: is_repeat expected %b actual %b", $time, want.is_repeat,
                     out_tuser[0]);
            mismatches++;
          end
          if (out_tuser[1] !== want.device_removed) begin
            $display("%0t: device_removed expected %b actual %b", $time,
                     want.device_removed, out_tuser[1]);
            mismatches++;
          end
        end
      end
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic set_idling(int mode);
    case (mode)
      0: begin idle_in_pct = 0;  stall_pct = 0;  end
      1: begin idle_in_pct = 46; stall_pct = 0;  end
      2: begin idle_in_pct = 0;  stall_pct = 46; end
      default: begin idle_in_pct = 30; stall_pct = 30; end
    endcase
  endtask

  task automatic cfg_write(cfg_addr_t addr, logic [TICK_W-1:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    case (addr)
      CFG_FIRST_DELAY:  dev_cfg.first_delay  = value;
      CFG_REPEAT_DELAY: dev_cfg.repeat_delay = value;
      CFG_MAX_REPEATS:  dev_cfg.max_repeats  = value;
      default: ;
    endcase
  endtask

  task automatic program_delays(logic [TICK_W-1:0] first, logic [TICK_W-1:0] rep,
                                logic [TICK_W-1:0] limit);
    cfg_write(CFG_FIRST_DELAY, first);
    cfg_write(CFG_REPEAT_DELAY, rep);
    cfg_write(CFG_MAX_REPEATS, limit);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cfg_addr  <= CFG_NONE;
  endtask

  task automatic drain();
    while (request_queue.size() != 0 || in_tvalid || key_events_due.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [KEY_CODE_W-1:0] pick_code();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 7);
      2: return last_code;
      default: return $urandom() >> $urandom_range(0, 31);
    endcase
  endfunction

  task automatic queue_press(logic [KEY_CODE_W-1:0] word);
    logic [LEN_W-1:0] len;
    len = $urandom_range(0, 1) ? LEN_LONG : LEN_SHORT;
    if (!is_press(len, word) || word == REMOVE_WORD)
      word = $urandom_range(3, 255);
    request_queue.push_back(make_req(REQ_REPORT, len, word));
    ticks_since_press = 0;
    last_code = word;
  endtask

  // keep expiries since the last press below the repeat limit so the unit never halts
  task automatic add_random(int count);
    int               pick;
    logic [LEN_W-1:0] len;
    logic [KEY_CODE_W-1:0] word;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      len  = LEN_W'($urandom_range(0, 15));
      word = $urandom();
      if (pick < 25) begin
        queue_press(pick_code());
      end else if (pick < 75) begin
        if (ticks_since_press + 1 >= dev_cfg.max_repeats) begin
          queue_press(pick_code());
        end else begin
          request_queue.push_back(make_req(REQ_TICK, len, word));
          ticks_since_press++;
        end
      end else if (pick < 88) begin
        if (len == LEN_LONG)
          word = '0;
        else if (len == LEN_SHORT)
          word = $urandom_range(0, 2);
        request_queue.push_back(make_req(REQ_REPORT, len, word));
      end else if (pick < 94) begin
        request_queue.push_back(make_req(REQ_UNUSED, len, word));
      end else begin
        if (is_press(len, word)) begin
          if (word == REMOVE_WORD)
            word = word ^ 32'd1;
          ticks_since_press = 0;
        end
        request_queue.push_back(make_req(REQ_REPORT, len, word));
      end
    end
  endtask

  initial begin
    int cause;
    set_idling(0);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed, register values from reset
    request_queue.push_back(make_req(REQ_TICK, 4'd0, 32'h0));
    request_queue.push_back(make_req(REQ_UNUSED, 4'hF, 32'hFFFF_FFFF));
    request_queue.push_back(make_req(REQ_REPORT, LEN_LONG, 32'h0));
    request_queue.push_back(make_req(REQ_REPORT, LEN_SHORT, 32'd2));
    request_queue.push_back(make_req(REQ_REPORT, LEN_SHORT, 32'd3));
    request_queue.push_back(make_req(REQ_REPORT, LEN_LONG, 32'hFFFF_FFFF));
    request_queue.push_back(make_req(REQ_REPORT, LEN_LONG, 32'hFFFF_FFFF));
    request_queue.push_back(make_req(REQ_REPORT, LEN_LONG, 32'd1));
    request_queue.push_back(make_req(REQ_REPORT, 4'd7, 32'h1234_5678));
    request_queue.push_back(make_req(REQ_REPORT, LEN_LONG, 32'd1));
    request_queue.push_back(make_req(REQ_REPORT, 4'hF, REMOVE_WORD));
    request_queue.push_back(make_req(REQ_REPORT, LEN_SHORT, 32'h00FF_FFFE));
    request_queue.push_back(make_req(REQ_TICK, 4'hF, 32'hFFFF_FFFF));
    request_queue.push_back(make_req(REQ_REPORT, 4'd0, 32'h0));
    drain();

    // directed, short delays for expiry
    program_delays(16'd2, 16'd1, 16'hFFFF);
    request_queue.push_back(make_req(REQ_REPORT, LEN_SHORT, 32'h8000_0000));
    request_queue.push_back(make_req(REQ_TICK, 4'd0, 32'h0));
    request_queue.push_back(make_req(REQ_TICK, 4'd0, 32'h0));
    request_queue.push_back(make_req(REQ_TICK, 4'd0, 32'h0));
    request_queue.push_back(make_req(REQ_REPORT, LEN_LONG, 32'h8000_0000));
    request_queue.push_back(make_req(REQ_TICK, 4'd0, 32'h0));
    request_queue.push_back(make_req(REQ_TICK, 4'd0, 32'h0));
    ticks_since_press = 2;
    last_code = 32'h8000_0000;
    drain();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: program_delays(FIRST_DELAY_RST, REPEAT_DELAY_RST, MAX_REPEATS_RST);
        1: program_delays(16'd1, 16'd1, 16'hFFFF);
        2: program_delays(16'hFFFF, 16'hFFFF, 16'd3);
        3: program_delays(16'd0, 16'd0, 16'd2);
        4: program_delays(TICK_W'($urandom_range(1, 6)), TICK_W'($urandom_range(1, 4)),
                          TICK_W'($urandom_range(20, 200)));
        default: program_delays(16'd2, 16'hFFFF, TICK_W'($urandom_range(5, 40)));
      endcase
      set_idling(p % 4);
      add_random(100);
      drain();
    end

    // one removal, then the unit must stay silent
    program_delays(16'd1, 16'd1, TICK_W'($urandom_range(0, 1)));
    set_idling(3);
    queue_press($urandom());
    cause = $urandom_range(0, 2);
    case (cause)
      0: request_queue.push_back(make_req(REQ_ERROR, LEN_W'($urandom_range(0, 15)),
                                          $urandom()));
      1: request_queue.push_back(make_req(REQ_REPORT,
                                          $urandom_range(0, 1) ? LEN_LONG : LEN_SHORT,
                                          REMOVE_WORD));
      default: request_queue.push_back(make_req(REQ_TICK, 4'd0, 32'h0));
    endcase
    for (int i = 0; i < 16; i++)
      request_queue.push_back(make_req(req_type_t'(2'($urandom_range(0, 3))),
                                       LEN_W'($urandom_range(0, 15)), $urandom()));
    drain();
    repeat (8) @(posedge clk);

    if (mismatches == 0 && key_events_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
